// File: rtl/mpq_pkg.sv
// Shared types and constants of the multilevel priority ready queue.
// No dependencies; every other file of the block imports this package.

package mpq_pkg;

    localparam int ID_W     = 8;
    localparam int PRIO_W   = 4;
    localparam int CMD_W    = 2;
    localparam int STATUS_W = 2;
    localparam int ACT_W    = 4;

    localparam logic [ACT_W-1:0] ACT_RESET = 4'd8;

    // APB register map: one 32-bit register at byte address 0.
    localparam int APB_ADDR_W = 3;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 1;
    localparam logic [REG_IDX_W-1:0] REG_ACTIVE_LEVELS = 1'b0;

    typedef enum logic [CMD_W-1:0] {
        CMD_ENQ  = 2'd0,
        CMD_DEQ  = 2'd1,
        CMD_REM  = 2'd2,
        CMD_NONE = 2'd3
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_ILLEGAL = 2'd1,
        ST_FULL    = 2'd2,
        ST_EMPTY   = 2'd3
    } status_t;

    typedef enum logic [1:0] {
        CELL_HOLD  = 2'd0,
        CELL_LOAD  = 2'd1,
        CELL_SHIFT = 2'd2
    } cell_op_t;

    // Control handed from the sequencer to one slot cell.
    typedef struct packed {
        cell_op_t        op;
        logic [ID_W-1:0] pid;
    } cell_cmd_t;

endpackage

// File: rtl/mpq_if.sv
// Valid/ready channel interfaces for requests and results of the queue.
// Depends on mpq_pkg for the field widths.

interface mpq_req_if import mpq_pkg::*;;
    logic              valid;
    logic              ready;
    logic [CMD_W-1:0]  command;
    logic [ID_W-1:0]   process_id;
    logic [PRIO_W-1:0] priority_req;

    modport source (output valid, command, process_id, priority_req, input ready);
    modport sink   (input valid, command, process_id, priority_req, output ready);
endinterface

interface mpq_rsp_if import mpq_pkg::*;;
    logic                valid;
    logic                ready;
    logic [STATUS_W-1:0] status;
    logic [ID_W-1:0]     result_id;

    modport source (output valid, status, result_id, input ready);
    modport sink   (input valid, status, result_id, output ready);
endinterface

// File: rtl/mpq_cell.sv
// One slot cell: holds the entry at one slot position for every priority level.
// Depends on mpq_pkg; instantiated in a row by the top level.

module mpq_cell import mpq_pkg::*;
#(
    parameter int MAX_LEVELS = 8
)
(
    input  logic                clk,
    input  logic [(MAX_LEVELS > 1 ? $clog2(MAX_LEVELS) : 1)-1:0] lvl,
    input  cell_cmd_t           cmd,
    input  logic [ID_W-1:0]     shift_in,
    output logic [ID_W-1:0]     rd_data,
    output logic                match
);

    logic [ID_W-1:0] entry_reg [MAX_LEVELS];

    // A shift takes the entry of the next cell up the row at the same level.
    always_ff @(posedge clk)
    begin
        case (cmd.op)
            CELL_LOAD:  entry_reg[lvl] <= cmd.pid;
            CELL_SHIFT: entry_reg[lvl] <= shift_in;
            default:    ;
        endcase
    end

    assign rd_data = entry_reg[lvl];
    assign match   = (rd_data == cmd.pid);

endmodule

// File: rtl/mpq_apb_regs.sv
// APB configuration register of the queue (active level count).
// Depends on mpq_pkg for the register map.

module mpq_apb_regs import mpq_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready,
    output logic [ACT_W-1:0]      active_levels
);

    logic [ACT_W-1:0]     active_reg;
    logic [ACT_W-1:0]     active_next;
    logic [REG_IDX_W-1:0] reg_idx;
    logic                 wr_en;

    assign reg_idx = paddr[APB_ADDR_W-1:2];
    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;

    always_comb
    begin
        active_next = active_reg;
        if (wr_en && (reg_idx == REG_ACTIVE_LEVELS))
        begin
            active_next = pwdata[ACT_W-1:0];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= ACT_RESET;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (reg_idx == REG_ACTIVE_LEVELS)
        begin
            prdata = {{(APB_DATA_W-ACT_W){1'b0}}, active_reg};
        end
    end

    assign active_levels = active_reg;

endmodule

// File: rtl/multilevel_priority_ready_queue_top.sv
// A ready queue of 8-bit process identifiers with one FIFO per priority level, level 0 the
// most urgent, stored in a row of SLOTS_PER_LEVEL slot cells that each hold one slot of every
// level. An accepted request passes the DECODE state and then DONE, which loads the output
// register, for an enqueue, a rejected request or a dequeue that finds every active level
// empty; a dequeue that returns an entry passes SHIFT between the two. A remove passes SCAN,
// which walks the slot match flags one slot per cycle and goes on to SHIFT when it finds the
// identifier or to DONE at the level's count when it is absent. A finished request waits in the
// sequencer while the output register still holds an untaken result. A further request is
// accepted once the previous one has left the sequencer, even while its result still waits in
// the output register.

module multilevel_priority_ready_queue_top import mpq_pkg::*;
#(
    parameter int MAX_LEVELS      = 8,
    parameter int SLOTS_PER_LEVEL = 16
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    mpq_req_if.sink               req,
    mpq_rsp_if.source             rsp,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [APB_ADDR_W-1:0] paddr,
    input  logic [APB_DATA_W-1:0] pwdata,
    output logic [APB_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int LVL_W  = (MAX_LEVELS > 1) ? $clog2(MAX_LEVELS) : 1;
    localparam int SLOT_W = $clog2(SLOTS_PER_LEVEL);
    localparam int CNT_W  = $clog2(SLOTS_PER_LEVEL + 1);
    localparam int NLEV_W = ACT_W + 1;
    localparam logic [NLEV_W-1:0] MAX_NLEV  = NLEV_W'(MAX_LEVELS);
    localparam logic [CNT_W-1:0]  FULL_CNT  = CNT_W'(SLOTS_PER_LEVEL);

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_SCAN,
        S_SHIFT,
        S_DONE
    } state_t;

    logic [ACT_W-1:0] active_levels;

    mpq_apb_regs u_regs (
        .clk           (clk),
        .rst_n         (rst_n),
        .psel          (psel),
        .penable       (penable),
        .pwrite        (pwrite),
        .paddr         (paddr),
        .pwdata        (pwdata),
        .prdata        (prdata),
        .pready        (pready),
        .active_levels (active_levels)
    );

    // Control registers
    state_t              state_reg, state_next;
    logic [CNT_W-1:0]    count_reg [MAX_LEVELS];
    logic [CNT_W-1:0]    count_next [MAX_LEVELS];
    logic                out_valid_reg, out_valid_next;
    status_t             out_status_reg, out_status_next;
    logic [ID_W-1:0]     out_rid_reg, out_rid_next;

    // Payload registers
    cmd_t                cmd_reg, cmd_next;
    logic [ID_W-1:0]     pid_reg, pid_next;
    logic [PRIO_W-1:0]   prio_reg, prio_next;
    logic [LVL_W-1:0]    lvl_reg, lvl_next;
    logic [CNT_W-1:0]    scan_reg, scan_next;
    logic [SLOTS_PER_LEVEL-1:0] match_reg, match_next;
    status_t             status_reg, status_next;
    logic [ID_W-1:0]     rid_reg, rid_next;

    logic [NLEV_W-1:0]   nlev;
    logic [LVL_W-1:0]    prio_lvl;
    logic                prio_ok;
    logic                deq_found;
    logic [LVL_W-1:0]    deq_lvl;
    logic [LVL_W-1:0]    cell_lvl;
    logic [CNT_W-1:0]    prio_count;
    logic [CNT_W-1:0]    lvl_count;
    logic                load_en;
    logic                shift_en;
    logic                accept;

    logic [ID_W-1:0]            cell_rd [SLOTS_PER_LEVEL];
    logic [SLOTS_PER_LEVEL-1:0] cell_match;
    cell_cmd_t                  cell_cmd [SLOTS_PER_LEVEL];

    assign nlev     = ({1'b0, active_levels} > MAX_NLEV) ? MAX_NLEV : {1'b0, active_levels};
    assign prio_lvl = prio_reg[LVL_W-1:0];
    assign prio_ok  = ({{(NLEV_W-PRIO_W){1'b0}}, prio_reg} < nlev);
    assign prio_count = count_reg[prio_lvl];
    assign lvl_count  = count_reg[lvl_reg];
    assign cell_lvl   = (state_reg == S_DECODE) ? prio_lvl : lvl_reg;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;

    // Most urgent active level that holds an entry.
    always_comb
    begin
        deq_found = 1'b0;
        deq_lvl   = '0;
        for (int l = MAX_LEVELS - 1; l >= 0; l--)
        begin
            if ((NLEV_W'(l) < nlev) && (count_reg[l] != '0))
            begin
                deq_found = 1'b1;
                deq_lvl   = LVL_W'(l);
            end
        end
    end

    always_comb
    begin
        state_next      = state_reg;
        count_next      = count_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_rid_next    = out_rid_reg;
        cmd_next        = cmd_reg;
        pid_next        = pid_reg;
        prio_next       = prio_reg;
        lvl_next        = lvl_reg;
        scan_next       = scan_reg;
        match_next      = match_reg;
        status_next     = status_reg;
        rid_next        = rid_reg;
        load_en         = 1'b0;
        shift_en        = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    cmd_next   = cmd_t'(req.command);
                    pid_next   = req.process_id;
                    prio_next  = req.priority_req;
                    state_next = S_DECODE;
                end
            end

            S_DECODE:
            begin
                rid_next    = '0;
                status_next = ST_ILLEGAL;
                state_next  = S_DONE;
                lvl_next    = prio_lvl;
                scan_next   = '0;
                case (cmd_reg)
                    CMD_ENQ:
                    begin
                        if (prio_ok && (prio_count == FULL_CNT))
                        begin
                            status_next = ST_FULL;
                        end
                        else if (prio_ok)
                        begin
                            load_en              = 1'b1;
                            count_next[prio_lvl] = prio_count + 1'b1;
                            status_next          = ST_OK;
                        end
                    end
                    CMD_DEQ:
                    begin
                        if (deq_found)
                        begin
                            lvl_next   = deq_lvl;
                            state_next = S_SHIFT;
                        end
                        else
                        begin
                            status_next = ST_EMPTY;
                        end
                    end
                    CMD_REM:
                    begin
                        if (prio_ok)
                        begin
                            match_next = cell_match;
                            state_next = S_SCAN;
                        end
                    end
                    default: ;
                endcase
            end

            S_SCAN:
            begin
                if (scan_reg == lvl_count)
                begin
                    status_next = ST_EMPTY;
                    state_next  = S_DONE;
                end
                else if (match_reg[scan_reg[SLOT_W-1:0]])
                begin
                    state_next = S_SHIFT;
                end
                else
                begin
                    scan_next = scan_reg + 1'b1;
                end
            end

            S_SHIFT:
            begin
                // Every cell from the vacated slot upwards takes its upper neighbour's entry.
                shift_en            = 1'b1;
                count_next[lvl_reg] = lvl_count - 1'b1;
                status_next         = ST_OK;
                rid_next            = (cmd_reg == CMD_DEQ) ? cell_rd[0] : pid_reg;
                state_next          = S_DONE;
            end

            S_DONE:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = status_reg;
                    out_rid_next    = rid_reg;
                    state_next      = S_IDLE;
                end
            end

            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            out_valid_reg  <= 1'b0;
            out_status_reg <= ST_OK;
            out_rid_reg    <= '0;
            for (int l = 0; l < MAX_LEVELS; l++)
            begin
                count_reg[l] <= '0;
            end
        end
        else
        begin
            state_reg      <= state_next;
            out_valid_reg  <= out_valid_next;
            out_status_reg <= out_status_next;
            out_rid_reg    <= out_rid_next;
            count_reg      <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg    <= cmd_next;
        pid_reg    <= pid_next;
        prio_reg   <= prio_next;
        lvl_reg    <= lvl_next;
        scan_reg   <= scan_next;
        match_reg  <= match_next;
        status_reg <= status_next;
        rid_reg    <= rid_next;
    end

    // Row of slot cells, slot 0 holding the head of each level.
    for (genvar g = 0; g < SLOTS_PER_LEVEL; g++)
    begin : g_cell
        logic [ID_W-1:0] upper;

        if (g == SLOTS_PER_LEVEL - 1)
        begin : g_last
            assign upper = '0;
        end
        else
        begin : g_mid
            assign upper = cell_rd[g+1];
        end

        always_comb
        begin
            cell_cmd[g].pid = pid_reg;
            cell_cmd[g].op  = CELL_HOLD;
            if (load_en && (CNT_W'(g) == prio_count))
            begin
                cell_cmd[g].op = CELL_LOAD;
            end
            else if (shift_en && (SLOT_W'(g) >= scan_reg[SLOT_W-1:0]))
            begin
                cell_cmd[g].op = CELL_SHIFT;
            end
        end

        mpq_cell #(
            .MAX_LEVELS (MAX_LEVELS)
        ) u_cell (
            .clk      (clk),
            .lvl      (cell_lvl),
            .cmd      (cell_cmd[g]),
            .shift_in (upper),
            .rd_data  (cell_rd[g]),
            .match    (cell_match[g])
        );
    end

    assign rsp.valid     = out_valid_reg;
    assign rsp.status    = out_status_reg;
    assign rsp.result_id = out_rid_reg;

endmodule

// File: rtl/mpq_checker.sv
// Port-level assertions for the multilevel priority ready queue.
// Depends on mpq_pkg; bound to multilevel_priority_ready_queue_top below.

module mpq_checker import mpq_pkg::*;
(
    input logic                clk,
    input logic                rst_n,
    input logic                req_valid,
    input logic                req_ready,
    input logic                rsp_valid,
    input logic                rsp_ready,
    input logic [STATUS_W-1:0] rsp_status,
    input logic [ID_W-1:0]     rsp_result_id
);

    logic [1:0] pending_reg;
    logic [1:0] pending_next;

    // Requests accepted whose results have not yet been taken.
    always_comb
    begin
        pending_next = pending_reg;
        if ((req_valid && req_ready) && !(rsp_valid && rsp_ready))
        begin
            pending_next = pending_reg + 1'b1;
        end
        else if (!(req_valid && req_ready) && (rsp_valid && rsp_ready))
        begin
            pending_next = pending_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pending_reg <= '0;
        end
        else
        begin
            pending_reg <= pending_next;
        end
    end

    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> rsp_valid)
        else $error("result withdrawn before it was taken");

    a_rsp_stable: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && !rsp_ready) |=> ($stable(rsp_status) && $stable(rsp_result_id)))
        else $error("stalled result changed");

    a_rid_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (rsp_valid && (rsp_status != ST_OK)) |-> (rsp_result_id == '0))
        else $error("identifier returned with a failing status");

    a_no_orphan: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (pending_reg != 2'd0))
        else $error("result without an outstanding request");

endmodule

bind multilevel_priority_ready_queue_top mpq_checker u_mpq_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .req_valid     (req.valid),
    .req_ready     (req.ready),
    .rsp_valid     (rsp.valid),
    .rsp_ready     (rsp.ready),
    .rsp_status    (rsp.status),
    .rsp_result_id (rsp.result_id)
);

// File: tb/multilevel_priority_ready_queue_top_tb.sv
`timescale 1ns / 100ps
// Testbench of the multilevel priority ready queue: directed and random requests are checked
// against a predictor of the per-level FIFOs. Depends on mpq_pkg, the channel interfaces in
// mpq_if and the multilevel_priority_ready_queue_top module.

module multilevel_priority_ready_queue_top_tb;
    import mpq_pkg::*;

    localparam int LEVELS      = 8;
    localparam int SLOTS       = 16;
    localparam int HOLD_CYCLES = 300;
    localparam int SETTLE      = 30;

    typedef struct {
        status_t         status;
        logic [ID_W-1:0] id;
    } outcome_t;

    logic                  clk     = 1'b0;
    logic                  rst_n   = 1'b0;
    logic                  psel    = 1'b0;
    logic                  penable = 1'b0;
    logic                  pwrite  = 1'b0;
    logic [APB_ADDR_W-1:0] paddr   = '0;
    logic [APB_DATA_W-1:0] pwdata  = '0;
    logic [APB_DATA_W-1:0] prdata;
    logic                  pready;

    mpq_req_if req_ch ();
    mpq_rsp_if rsp_ch ();

    multilevel_priority_ready_queue_top #(
        .MAX_LEVELS      (LEVELS),
        .SLOTS_PER_LEVEL (SLOTS)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .req     (req_ch),
        .rsp     (rsp_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // Predicted contents of the queue, kept in step with accepted requests.
    logic [ID_W-1:0]  held_ids [LEVELS][SLOTS];
    int unsigned      held_count [LEVELS] = '{default: 0};
    logic [ACT_W-1:0] levels_reg = ACT_RESET;

    outcome_t pending_results [$];
    int       errors         = 0;
    int       send_idle_pct  = 0;
    int       recv_stall_pct = 0;
    logic     hold_off       = 1'b0;
    event     start_hold;

    always #6 clk = ~clk;

    function automatic int unsigned active_level_count();
        return (levels_reg > LEVELS) ? LEVELS : levels_reg;
    endfunction

    function automatic void drop_slot(int unsigned lvl, int unsigned pos);
        for (int unsigned i = pos; i + 1 < held_count[lvl]; i++)
            held_ids[lvl][i] = held_ids[lvl][i + 1];
        held_count[lvl]--;
    endfunction

    function automatic outcome_t predict_outcome(cmd_t cmd, logic [ID_W-1:0] pid,
                                                 logic [PRIO_W-1:0] prio);
        outcome_t    res;
        int unsigned nlev;
        int unsigned lvl;
        res.status = ST_ILLEGAL;
        res.id     = '0;
        nlev       = active_level_count();
        lvl        = 32'(prio);
        case (cmd)
            CMD_ENQ:
            begin
                if (lvl < nlev)
                begin
                    if (held_count[lvl] >= SLOTS)
                        res.status = ST_FULL;
                    else
                    begin
                        held_ids[lvl][held_count[lvl]] = pid;
                        held_count[lvl]++;
                        res.status = ST_OK;
                    end
                end
            end
            CMD_DEQ:
            begin
                res.status = ST_EMPTY;
                for (int unsigned i = 0; i < nlev; i++)
                begin
                    if (held_count[i] != 0)
                    begin
                        res.id     = held_ids[i][0];
                        res.status = ST_OK;
                        drop_slot(i, 0);
                        break;
                    end
                end
            end
            CMD_REM:
            begin
                if (lvl < nlev)
                begin
                    res.status = ST_EMPTY;
                    // The oldest matching entry goes; the rest keep their order.
                    for (int unsigned i = 0; i < held_count[lvl]; i++)
                    begin
                        if (held_ids[lvl][i] == pid)
                        begin
                            res.id     = pid;
                            res.status = ST_OK;
                            drop_slot(lvl, i);
                            break;
                        end
                    end
                end
            end
            default:
            begin
            end
        endcase
        return res;
    endfunction

    task automatic send_request(cmd_t cmd, logic [ID_W-1:0] pid, logic [PRIO_W-1:0] prio);
        int idle;
        idle = 0;
        while ($urandom_range(99) < send_idle_pct)
            idle++;
        if (idle > 0)
        begin
            req_ch.valid <= 1'b0;
            repeat (idle) @(posedge clk);
        end
        req_ch.valid        <= 1'b1;
        req_ch.command      <= cmd;
        req_ch.process_id   <= pid;
        req_ch.priority_req <= prio;
        @(posedge clk);
        while (!req_ch.ready)
            @(posedge clk);
        pending_results.push_back(predict_outcome(cmd, pid, prio));
    endtask

    task automatic send_random(int count, int enq_pct, int rem_pct);
        cmd_t              cmd;
        logic [ID_W-1:0]   pid;
        logic [PRIO_W-1:0] prio;
        int unsigned       nlev;
        int unsigned       lvl;
        int unsigned       pick;
        for (int n = 0; n < count; n++)
        begin
            pick = $urandom_range(99);
            pid  = ID_W'($urandom);
            nlev = active_level_count();
            if (pick < enq_pct)
                cmd = CMD_ENQ;
            else if (pick < enq_pct + rem_pct)
                cmd = CMD_REM;
            else if (pick < 97)
                cmd = CMD_DEQ;
            else
                cmd = CMD_NONE;
            // Priorities mostly fall in the active range, now and then anywhere.
            if ($urandom_range(9) == 0 || nlev == 0)
                prio = PRIO_W'($urandom_range(15));
            else
                prio = PRIO_W'($urandom_range(nlev - 1));
            // Most removals name an identifier that is actually held somewhere.
            if (cmd == CMD_REM && $urandom_range(3) != 0)
            begin
                lvl = $urandom_range(LEVELS - 1);
                if (held_count[lvl] != 0)
                begin
                    prio = PRIO_W'(lvl);
                    pid  = held_ids[lvl][$urandom_range(held_count[lvl] - 1)];
                end
            end
            send_request(cmd, pid, prio);
        end
    endtask

    task automatic wait_idle();
        req_ch.valid <= 1'b0;
        while (pending_results.size() != 0)
            @(posedge clk);
        repeat (SETTLE) @(posedge clk);
    endtask

    task automatic write_active_levels(logic [ACT_W-1:0] value);
        logic [APB_DATA_W-1:0] word;
        word              = $urandom;
        word[ACT_W-1:0]   = value;
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= APB_ADDR_W'(4 * REG_ACTIVE_LEVELS);
        pwdata  <= word;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        levels_reg = value;
    endtask

    task automatic set_idling(int send_pct, int recv_pct);
        send_idle_pct  = send_pct;
        recv_stall_pct = recv_pct;
    endtask

    task automatic test_directed();
        set_idling(0, 0);
        send_request(CMD_DEQ, 8'h00, 4'd0);
        send_request(CMD_REM, 8'h33, 4'd2);
        send_request(CMD_ENQ, 8'h00, 4'd0);
        send_request(CMD_ENQ, 8'hFF, 4'd7);
        send_request(CMD_ENQ, 8'h5A, 4'd3);
        send_request(CMD_ENQ, 8'hA5, 4'd3);
        send_request(CMD_ENQ, 8'h5A, 4'd3);
        send_request(CMD_ENQ, 8'h11, 4'd8);
        send_request(CMD_ENQ, 8'h22, 4'd15);
        send_request(CMD_REM, 8'hFF, 4'd15);
        send_request(CMD_NONE, 8'hFF, 4'd15);
        send_request(CMD_REM, 8'h5A, 4'd3);
        send_request(CMD_REM, 8'h77, 4'd3);
        send_request(CMD_DEQ, 8'hFF, 4'd15);
        send_request(CMD_DEQ, 8'h00, 4'd0);
        send_request(CMD_ENQ, 8'h3C, 4'd6);
        wait_idle();
    endtask

    // A single active level fills up quickly, so full-level rejections are frequent.
    task automatic test_single_level();
        write_active_levels(4'd1);
        set_idling(45, 0);
        send_random(60, 70, 15);
        wait_idle();
    endtask

    task automatic test_no_levels();
        write_active_levels(4'd0);
        set_idling(0, 0);
        send_random(15, 40, 30);
        wait_idle();
    endtask

    // Entries left in the upper levels must stay out of reach here.
    task automatic test_switched_off_levels();
        write_active_levels(4'd4);
        set_idling(0, 45);
        send_random(60, 45, 25);
        wait_idle();
    endtask

    // A count above the number of levels behaves as all levels.
    task automatic test_clamped_levels();
        write_active_levels(4'd15);
        set_idling(23, 23);
        send_random(80, 40, 25);
        wait_idle();
    endtask

    task automatic test_backpressure();
        write_active_levels(4'd8);
        set_idling(0, 0);
        -> start_hold;
        send_random(40, 50, 20);
        wait_idle();
    endtask

    task automatic test_random_mix();
        for (int round = 0; round < 4; round++)
        begin
            write_active_levels(4'($urandom_range(2, 8)));
            case (round)
                0: set_idling(0, 0);
                1: set_idling(45, 0);
                2: set_idling(0, 45);
                default: set_idling(23, 23);
            endcase
            send_random(35, 40, 25);
            wait_idle();
        end
    endtask

    always @(posedge clk)
    begin
        rsp_ch.ready <= !hold_off && ($urandom_range(99) >= recv_stall_pct);
    end

    // Long receiver hold-off, counted here so that the sender carries on meanwhile.
    initial
    begin
        forever
        begin
            @(start_hold);
            hold_off <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clk);
            hold_off <= 1'b0;
        end
    end

    always @(posedge clk)
    begin
        outcome_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_results.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result: expected none, actual status %0d id %0d",
                         $time, rsp_ch.status, rsp_ch.result_id);
            end
            else
            begin
                want = pending_results.pop_front();
                if (rsp_ch.status !== want.status)
                begin
                    errors++;
                    $display("%0t: status mismatch: expected %0d, actual %0d",
                             $time, want.status, rsp_ch.status);
                end
                if (rsp_ch.result_id !== want.id)
                begin
                    errors++;
                    $display("%0t: result_id mismatch: expected %0d, actual %0d",
                             $time, want.id, rsp_ch.result_id);
                end
            end
        end
    end

    initial
    begin
        #2_000_000;
        $display("*** FAILED ***");
        $finish;
    end

    initial
    begin
        req_ch.valid        = 1'b0;
        req_ch.command      = CMD_ENQ;
        req_ch.process_id   = '0;
        req_ch.priority_req = '0;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed();
        test_single_level();
        test_no_levels();
        test_switched_off_levels();
        test_clamped_levels();
        test_backpressure();
        test_random_mix();

        if (errors == 0 && pending_results.size() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
